@@ src/efp_pkg.sv @@
// Types and constants of the encoder frame parser.
package efp_pkg;

    localparam logic [7:0] HEADER_FIRST  = 8'h5A;
    localparam logic [7:0] HEADER_SECOND = 8'h7E;
    localparam logic [7:0] FLAG_RESET    = 8'hC1;

    typedef enum logic [3:0] {
        P_HDR1  = 4'd1,
        P_HDR2  = 4'd2,
        P_FLAG  = 4'd3,
        P_POS_H = 4'd4,
        P_POS_M = 4'd5,
        P_POS_L = 4'd6,
        P_CNT_H = 4'd7,
        P_CNT_L = 4'd8,
        P_SUM_H = 4'd9,
        P_SUM_L = 4'd10
    } progress_t;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_HDR_ERR = 2'd1,
        ST_GOOD    = 2'd2,
        ST_SUM_ERR = 2'd3
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } step_word_t;

endpackage

@@ src/efp_core.sv @@
// Frame state machine, field assembly, checksum and result register.
module efp_core
    import efp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       flag_byte,
    input  step_word_t       step,
    output logic             step_ready,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       status,
    output logic [23:0]      position,
    output logic [15:0]      frame_counter
);

    progress_t   progress_reg, progress_next;
    logic [23:0] position_acc_reg, position_acc_next;
    logic [15:0] counter_acc_reg, counter_acc_next;
    logic [15:0] checksum_rx_reg, checksum_rx_next;
    logic [15:0] checksum_sum_reg, checksum_sum_next;
    logic [7:0]  high_byte_hold_reg, high_byte_hold_next;

    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;
    logic [23:0] position_reg, position_next;
    logic [15:0] frame_counter_reg, frame_counter_next;

    logic        fire;
    logic        mismatch;
    logic [15:0] sum_added;
    logic [7:0]  b;

    assign b          = step.rx_byte;
    assign step_ready = !out_valid_reg || !out_stall;
    assign fire       = step.valid && step_ready;
    assign sum_added  = checksum_sum_reg + {high_byte_hold_reg, b};

    always_comb
    begin
        progress_next       = progress_reg;
        position_acc_next   = position_acc_reg;
        counter_acc_next    = counter_acc_reg;
        checksum_rx_next    = checksum_rx_reg;
        checksum_sum_next   = checksum_sum_reg;
        high_byte_hold_next = high_byte_hold_reg;
        status_next         = ST_BUSY;
        position_next       = 24'd0;
        frame_counter_next  = 16'd0;
        mismatch            = 1'b0;

        unique case (progress_reg)
            P_HDR1:
            begin
                if (b == HEADER_FIRST)
                begin
                    position_acc_next = 24'd0;
                    progress_next     = P_HDR2;
                end
                else
                begin
                    mismatch = 1'b1;
                end
            end
            P_HDR2:
            begin
                if (b == HEADER_SECOND)
                begin
                    progress_next = P_FLAG;
                end
                else
                begin
                    mismatch = 1'b1;
                end
            end
            P_FLAG:
            begin
                if (b == flag_byte)
                begin
                    high_byte_hold_next = b;
                    checksum_sum_next   = 16'd0;
                    progress_next       = P_POS_H;
                end
                else
                begin
                    mismatch = 1'b1;
                end
            end
            P_POS_H:
            begin
                position_acc_next = {b, position_acc_reg[15:0]};
                checksum_sum_next = sum_added;
                progress_next     = P_POS_M;
            end
            P_POS_M:
            begin
                position_acc_next   = {position_acc_reg[23:16], b, position_acc_reg[7:0]};
                high_byte_hold_next = b;
                progress_next       = P_POS_L;
            end
            P_POS_L:
            begin
                position_acc_next = {position_acc_reg[23:8], b};
                checksum_sum_next = sum_added;
                progress_next     = P_CNT_H;
            end
            P_CNT_H:
            begin
                counter_acc_next    = {b, counter_acc_reg[7:0]};
                high_byte_hold_next = b;
                progress_next       = P_CNT_L;
            end
            P_CNT_L:
            begin
                counter_acc_next  = {counter_acc_reg[15:8], b};
                checksum_sum_next = sum_added;
                progress_next     = P_SUM_H;
            end
            P_SUM_H:
            begin
                checksum_rx_next = {b, checksum_rx_reg[7:0]};
                progress_next    = P_SUM_L;
            end
            P_SUM_L:
            begin
                if ({checksum_rx_reg[15:8], b} == checksum_sum_reg)
                begin
                    status_next        = ST_GOOD;
                    position_next      = position_acc_reg;
                    frame_counter_next = counter_acc_reg;
                end
                else
                begin
                    status_next = ST_SUM_ERR;
                end
                counter_acc_next  = 16'd0;
                checksum_rx_next  = 16'd0;
                checksum_sum_next = 16'd0;
                progress_next     = P_HDR1;
            end
            default:
            begin
                mismatch = 1'b1;
            end
        endcase

        if (mismatch)
        begin
            status_next   = ST_HDR_ERR;
            progress_next = P_HDR1;
        end
    end

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progress_reg       <= P_HDR1;
            position_acc_reg   <= 24'd0;
            counter_acc_reg    <= 16'd0;
            checksum_rx_reg    <= 16'd0;
            checksum_sum_reg   <= 16'd0;
            high_byte_hold_reg <= 8'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                progress_reg       <= progress_next;
                position_acc_reg   <= position_acc_next;
                counter_acc_reg    <= counter_acc_next;
                checksum_rx_reg    <= checksum_rx_next;
                checksum_sum_reg   <= checksum_sum_next;
                high_byte_hold_reg <= high_byte_hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg        <= status_next;
            position_reg      <= position_next;
            frame_counter_reg <= frame_counter_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign position      = position_reg;
    assign frame_counter = frame_counter_reg;

    a_last_byte_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && progress_reg == P_SUM_L |=> progress_reg == P_HDR1)
        else $error("frame end did not return to first header");

    a_payload_no_hdr_err: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (progress_reg == P_POS_H || progress_reg == P_POS_M ||
                 progress_reg == P_POS_L || progress_reg == P_CNT_H ||
                 progress_reg == P_CNT_L || progress_reg == P_SUM_H ||
                 progress_reg == P_SUM_L)
        |=> status_reg != ST_HDR_ERR)
        else $error("header error reported in payload phase");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_GOOD
        |-> position_reg == 24'd0 && frame_counter_reg == 16'd0)
        else $error("fields nonzero without good frame");

    a_result_follows_fire: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("accepted word produced no result");

endmodule

@@ src/encoder_frame_parser.sv @@
// Top level: flag register, input word register and frame parser core.
// Path: an accepted byte goes into the input word register, then its result into the result register.
// Throughput: one byte per cycle; the input register advances whenever the result register is
// free or being taken, and the whole frame step is one pass of the core logic.
// Reset: asynchronous active low; parser returns to the first header, accumulators clear,
// flag byte returns to 0xC1, no result is pending.
module encoder_frame_parser
    import efp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [23:0] position,
    output logic [15:0] frame_counter
);

    logic [7:0] flag_byte_reg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] rx_byte_reg;
    logic       step_ready;
    logic       in_accept;
    step_word_t step;

    assign cfg_ready = 1'b1;
    assign in_stall  = in_valid_reg && !step_ready;
    assign in_accept = in_valid && !in_stall;

    assign step.valid   = in_valid_reg;
    assign step.rx_byte = rx_byte_reg;

    always_comb
    begin
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_ready)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_byte_reg <= FLAG_RESET;
            in_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                flag_byte_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rx_byte_reg <= rx_byte;
        end
    end

    efp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .flag_byte     (flag_byte_reg),
        .step          (step),
        .step_ready    (step_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .position      (position),
        .frame_counter (frame_counter)
    );

endmodule
